/* rtl/move_toward_target_step_unit_macros.svh */
// Assertion macros for the move-toward-target step unit.
`ifndef MOVE_TOWARD_TARGET_STEP_UNIT_MACROS_SVH
`define MOVE_TOWARD_TARGET_STEP_UNIT_MACROS_SVH
`ifndef SYNTH
`define MTT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MTT_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MTT_ASSERT(lbl, clk, rst_n, prop, msg)
`define MTT_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

/* rtl/mtt_pkg.sv */
// ----------------------------------------------------------------------------
// mtt_pkg: shared types and constants
// Field widths, stage payload struct and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package mtt_pkg;

  localparam int unsigned PosW   = 24;
  localparam int unsigned DiffW  = 25;
  localparam int unsigned SqW    = 51;  // dx^2 + dy^2
  localparam int unsigned LenW   = 26;  // floor(sqrt(S))
  localparam int unsigned ProdW  = 32;  // speed * frame_time
  localparam int unsigned NumW   = 57;  // P * |d|
  localparam int unsigned DenW   = 34;  // 256 * L
  localparam int unsigned QuoW   = 57;
  localparam int unsigned CxW    = 36;  // CORDIC x/y
  localparam int unsigned ZW     = 33;  // angle, 2^-23 degree
  localparam int unsigned HeadW  = 16;
  localparam int unsigned TabLen = 24;
  localparam int unsigned RadW   = 8;

  localparam logic signed [ZW-1:0] Deg180Fine = 33'sd1509949440;
  localparam logic signed [HeadW-1:0] HeadLim = 16'sd23040;
  localparam logic [RadW-1:0] RadReset = 8'd3;

  function automatic logic [ZW-1:0] atan_tab(input logic [4:0] i);
    logic [ZW-1:0] r;
    case (i)
      5'd0: r = 33'd377487360;  5'd1: r = 33'd222843801;
      5'd2: r = 33'd117744544;  5'd3: r = 33'd59768969;
      5'd4: r = 33'd30000467;   5'd5: r = 33'd15014858;
      5'd6: r = 33'd7509261;    5'd7: r = 33'd3754860;
      5'd8: r = 33'd1877459;    5'd9: r = 33'd938733;
      5'd10: r = 33'd469367;    5'd11: r = 33'd234683;
      5'd12: r = 33'd117342;    5'd13: r = 33'd58671;
      5'd14: r = 33'd29335;     5'd15: r = 33'd14668;
      5'd16: r = 33'd7334;      5'd17: r = 33'd3667;
      5'd18: r = 33'd1833;      5'd19: r = 33'd917;
      5'd20: r = 33'd458;       5'd21: r = 33'd229;
      5'd22: r = 33'd115;       5'd23: r = 33'd57;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Payload riding the cell chain.
  typedef struct packed {
    logic                    vld;
    logic signed [PosW-1:0]  cx;
    logic signed [PosW-1:0]  cy;
    logic signed [DiffW-1:0] dx;
    logic signed [DiffW-1:0] dy;
    logic [ProdW-1:0]        p;
    logic                    arr;
    // root
    logic [SqW-1:0]          rem;
    logic [LenW-1:0]         root;
    // dividers
    logic [NumW-1:0]         nx;
    logic [NumW-1:0]         ny;
    logic [QuoW-1:0]         qx;
    logic [QuoW-1:0]         qy;
    // cordic
    logic signed [CxW-1:0]   x;
    logic signed [CxW-1:0]   y;
    logic signed [ZW-1:0]    z;
  } cell_t;

endpackage

/* rtl/mtt_stream_if.sv */
// ----------------------------------------------------------------------------
// mtt_in_if / mtt_out_if: valid/ready word channels
// Input point words and result words.
// ----------------------------------------------------------------------------
interface mtt_in_if;
  logic valid;
  logic ready;
  logic signed [23:0] current_x;
  logic signed [23:0] current_y;
  logic signed [23:0] target_x;
  logic signed [23:0] target_y;
  logic [15:0] speed;
  logic [15:0] frame_time;
  modport source (output valid, current_x, current_y, target_x, target_y, speed,
                  frame_time, input ready);
  modport sink (input valid, current_x, current_y, target_x, target_y, speed,
                frame_time, output ready);
endinterface

interface mtt_out_if;
  logic valid;
  logic ready;
  logic signed [23:0] new_x;
  logic signed [23:0] new_y;
  logic signed [15:0] heading;
  logic arrived;
  modport source (output valid, new_x, new_y, heading, arrived, input ready);
  modport sink (input valid, new_x, new_y, heading, arrived, output ready);
endinterface

/* rtl/mtt_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// mtt_sqrt_cell: one digit of the restoring integer square root
// Handles one result bit (bit pair of S) per cycle when en_i is high.
// ----------------------------------------------------------------------------
module mtt_sqrt_cell #(
  parameter int unsigned Bit = 0  // result bit handled here
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  mtt_pkg::cell_t  c_i,
  output mtt_pkg::cell_t  c_o
);
  localparam int unsigned TrW = mtt_pkg::SqW + 2;
  logic [TrW-1:0] trial, remx;
  mtt_pkg::cell_t c_d;

  always_comb begin
    c_d   = c_i;
    // setting this bit adds (4r+1)*4^Bit to the square, r = root so far
    trial = ((TrW'(c_i.root) << 2) | TrW'(1)) << (2 * Bit);
    remx  = TrW'(c_i.rem);
    if (remx >= trial) begin
      c_d.rem  = mtt_pkg::SqW'(remx - trial);
      c_d.root = (c_i.root << 1) | mtt_pkg::LenW'(1);
    end else begin
      c_d.root = c_i.root << 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_o <= c_d;
    end
  end
endmodule

/* rtl/mtt_div_cell.sv */
// ----------------------------------------------------------------------------
// mtt_div_cell: one quotient bit for both step dividers plus one CORDIC step
// Restoring division bit on x and y, CORDIC micro-rotation when enabled.
// ----------------------------------------------------------------------------
module mtt_div_cell #(
  parameter int unsigned Bit   = 0,  // quotient bit handled here
  parameter int unsigned CStep = 0,  // CORDIC iteration index
  parameter bit          CEn   = 1'b0
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  mtt_pkg::cell_t  c_i,
  output mtt_pkg::cell_t  c_o
);
  localparam int unsigned RW = mtt_pkg::NumW + mtt_pkg::DenW;
  logic [RW-1:0] den_sh;
  logic signed [mtt_pkg::CxW-1:0] xs, ys;
  mtt_pkg::cell_t c_d;

  always_comb begin
    c_d    = c_i;
    // divisor 256*L, zero length never reaches here unarrived
    den_sh = (RW'(c_i.root) << 8) << Bit;
    if (RW'(c_i.nx) >= den_sh) begin
      c_d.nx = mtt_pkg::NumW'(RW'(c_i.nx) - den_sh);
      c_d.qx = c_i.qx | (mtt_pkg::QuoW'(1) << Bit);
    end
    if (RW'(c_i.ny) >= den_sh) begin
      c_d.ny = mtt_pkg::NumW'(RW'(c_i.ny) - den_sh);
      c_d.qy = c_i.qy | (mtt_pkg::QuoW'(1) << Bit);
    end
    xs = c_i.x >>> CStep;
    ys = c_i.y >>> CStep;
    if (CEn) begin
      if (c_i.y > 0) begin
        c_d.x = c_i.x + ys;
        c_d.y = c_i.y - xs;
        c_d.z = c_i.z + $signed(mtt_pkg::atan_tab(5'(CStep)));
      end else begin
        c_d.x = c_i.x - ys;
        c_d.y = c_i.y + xs;
        c_d.z = c_i.z - $signed(mtt_pkg::atan_tab(5'(CStep)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_o <= c_d;
    end
  end
endmodule

/* rtl/move_toward_target_step_unit.sv */
// ----------------------------------------------------------------------------
// move_toward_target_step_unit: step a point toward its target
// Pipelined length, step and heading over a chain of identical digit cells.
// ----------------------------------------------------------------------------
// One input word in every cycle unless the output stalls, one result word per
// input. A word passes 1 + 26 + 57 + 1 registers: an entry stage forms dx,
// dy, S and speed*time, a 26-cell chain takes the square root one bit per
// cell, a 57-cell chain takes both step quotients one bit per cell while the
// first CORDIC_STAGES (at most 24) of those cells also run the heading CORDIC,
// then an exit stage rounds, saturates and picks the arrival result. The whole
// chain advances when the output register is empty or being read, so a stalled
// output stalls input. The user must write arrive_radius through cfg_we_i/
// cfg_wdata_i only while idle; the block itself does not enforce this.
module move_toward_target_step_unit #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  mtt_in_if.sink     in_if,
  mtt_out_if.source  out_if
);
  `include "move_toward_target_step_unit_macros.svh"

  localparam int unsigned NSq  = mtt_pkg::LenW;
  localparam int unsigned NDiv = mtt_pkg::QuoW;
  localparam int unsigned NC   = (CORDIC_STAGES < mtt_pkg::TabLen) ? CORDIC_STAGES
                                                                   : mtt_pkg::TabLen;
  localparam int unsigned NCell = NSq + NDiv;

  logic [7:0] radius_q;
  logic       adv;
  logic [NCell:0] vld_q;  // entry and cells

  mtt_pkg::cell_t chain [NCell+1];
  mtt_pkg::cell_t entry_d;

  // output register
  logic              ovld_q;
  logic signed [23:0] ox_q, oy_q;
  logic signed [15:0] oh_q;
  logic              oa_q;

  assign adv = !ovld_q || out_if.ready;
  assign in_if.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= mtt_pkg::RadReset;
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  // entry stage
  always_comb begin
    logic signed [mtt_pkg::DiffW-1:0] dx, dy;
    logic signed [mtt_pkg::CxW-1:0]   x0, y0;
    entry_d     = '0;
    dx          = mtt_pkg::DiffW'(in_if.target_x) - mtt_pkg::DiffW'(in_if.current_x);
    dy          = mtt_pkg::DiffW'(in_if.target_y) - mtt_pkg::DiffW'(in_if.current_y);
    entry_d.vld = in_if.valid;
    entry_d.cx  = in_if.current_x;
    entry_d.cy  = in_if.current_y;
    entry_d.dx  = dx;
    entry_d.dy  = dy;
    entry_d.p   = in_if.speed * in_if.frame_time;
    entry_d.rem = mtt_pkg::SqW'(dx * dx) + mtt_pkg::SqW'(dy * dy);
    x0 = mtt_pkg::CxW'(dx) <<< 8;
    y0 = mtt_pkg::CxW'(dy) <<< 8;
    if (dx < 0) begin
      entry_d.x = -x0;
      entry_d.y = -y0;
      entry_d.z = (dy > 0) ? mtt_pkg::Deg180Fine : -mtt_pkg::Deg180Fine;
    end else begin
      entry_d.x = x0;
      entry_d.y = y0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      chain[0] <= entry_d;
    end
  end

  // square root cells, MSB first
  for (genvar g = 0; g < NSq; g++) begin : g_sq
    mtt_sqrt_cell #(.Bit(NSq - 1 - g)) u_cell (
      .clk_i(clk_i), .en_i(adv), .c_i(chain[g]), .c_o(chain[g+1]));
  end

  // step numerators formed between chains
  mtt_pkg::cell_t mid;
  always_comb begin
    logic [mtt_pkg::DiffW-1:0] ax, ay;
    mid = chain[NSq];
    ax  = chain[NSq].dx[mtt_pkg::DiffW-1] ? mtt_pkg::DiffW'(-chain[NSq].dx)
                                          : chain[NSq].dx;
    ay  = chain[NSq].dy[mtt_pkg::DiffW-1] ? mtt_pkg::DiffW'(-chain[NSq].dy)
                                          : chain[NSq].dy;
    mid.arr = (chain[NSq].root[mtt_pkg::LenW-1:8] <= 18'(radius_q));
    mid.nx  = mtt_pkg::NumW'(chain[NSq].p) * mtt_pkg::NumW'(ax);
    mid.ny  = mtt_pkg::NumW'(chain[NSq].p) * mtt_pkg::NumW'(ay);
    mid.qx  = '0;
    mid.qy  = '0;
  end

  for (genvar g = 0; g < NDiv; g++) begin : g_div
    mtt_pkg::cell_t cin;
    if (g == 0) begin : g_first
      assign cin = mid;
    end else begin : g_rest
      assign cin = chain[NSq+g];
    end
    mtt_div_cell #(.Bit(NDiv - 1 - g), .CStep(g), .CEn(g < NC)) u_cell (
      .clk_i(clk_i), .en_i(adv), .c_i(cin), .c_o(chain[NSq+g+1]));
  end

  // exit stage
  mtt_pkg::cell_t last;
  logic signed [mtt_pkg::ZW-1:0] zr;
  logic signed [26:0] hz;
  logic signed [15:0] head;
  logic signed [58:0] sx, sy;
  logic signed [23:0] nxs, nys;
  assign last = chain[NCell];
  always_comb begin
    zr = last.z + mtt_pkg::ZW'(32768);
    hz = 27'(zr >>> 16);
    if (last.dy == '0) begin
      head = last.dx[mtt_pkg::DiffW-1] ? mtt_pkg::HeadLim : '0;
    end else if (hz > 27'(mtt_pkg::HeadLim)) begin
      head = mtt_pkg::HeadLim;
    end else if (hz < -27'(mtt_pkg::HeadLim)) begin
      head = -mtt_pkg::HeadLim;
    end else begin
      head = 16'(hz);
    end
    sx = 59'(last.cx) + (last.dx[mtt_pkg::DiffW-1] ? -$signed({2'b0, last.qx})
                                                   : $signed({2'b0, last.qx}));
    sy = 59'(last.cy) + (last.dy[mtt_pkg::DiffW-1] ? -$signed({2'b0, last.qy})
                                                   : $signed({2'b0, last.qy}));
    nxs = (sx > 59'sd8388607) ? 24'sh7FFFFF : (sx < -59'sd8388608) ? 24'sh800000
                                                                : 24'(sx);
    nys = (sy > 59'sd8388607) ? 24'sh7FFFFF : (sy < -59'sd8388608) ? 24'sh800000
                                                                : 24'(sy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      ovld_q <= 1'b0;
    end else if (adv) begin
      vld_q  <= {vld_q[NCell-1:0], in_if.valid};
      ovld_q <= last.vld & vld_q[NCell];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ox_q <= last.arr ? last.cx : nxs;
      oy_q <= last.arr ? last.cy : nys;
      oh_q <= last.arr ? 16'sd0 : head;
      oa_q <= last.arr;
    end
  end

  assign out_if.valid   = ovld_q;
  assign out_if.new_x   = ox_q;
  assign out_if.new_y   = oy_q;
  assign out_if.heading = oh_q;
  assign out_if.arrived = oa_q;

  `MTT_ASSERT(a_hold, clk_i, rst_ni, ovld_q && !out_if.ready |=> ovld_q && $stable(oh_q),
              "result word dropped while stalled")
  `MTT_ASSERT(a_rdy, clk_i, rst_ni, in_if.ready == (!ovld_q || out_if.ready),
              "input ready not tied to output register")
  `MTT_ASSERT(a_arr, clk_i, rst_ni, ovld_q && oa_q |-> oh_q == 16'sd0,
              "arrival with nonzero heading")
endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: move-toward-target step unit
// Sends point words through the input channel and checks every result word.
// Each result is compared with a bit-exact prediction of length, step and
// heading. Both channel sides idle at random. Arrival radius settings run
// in phases, and one long output hold-off fills the pipeline.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // one input word as a record
  typedef struct {
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic signed [23:0] tx;
    logic signed [23:0] ty;
    logic [15:0]        spd;
    logic [15:0]        ft;
  } point_t;

  // one predicted result word
  typedef struct {
    logic signed [23:0] nx;
    logic signed [23:0] ny;
    logic signed [15:0] hd;
    logic               arr;
  } move_t;

  localparam int unsigned Stages = 16;
  localparam int unsigned Drain  = 120;   // longer than the pipeline latency
  localparam longint      PosMax = 64'sd8388607;
  localparam longint      PosMin = -64'sd8388608;

  localparam longint AtanFine [24] = '{
    377487360, 222843801, 117744544, 59768969, 30000467,
    15014858, 7509261, 3754860, 1877459, 938733, 469367,
    234683, 117342, 58671, 29335, 14668, 7334, 3667,
    1833, 917, 458, 229, 115, 57
  };

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [7:0] cfg_wdata_i;

  mtt_in_if  in_if();
  mtt_out_if out_if();

  move_toward_target_step_unit #(.CORDIC_STAGES(Stages)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_if.sink),
    .out_if     (out_if.source)
  );

  move_t       pending_moves[$];   // predicted words, oldest first
  logic [7:0]  radius_q;           // our copy of arrive_radius
  int unsigned mismatches;
  bit          calm;               // no idling on either side while set
  int unsigned hold_req;           // requested output hold-off, cycles

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint unsigned root_floor(input longint unsigned s);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s   = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // CORDIC vectoring, angle in 2^-23 degree, then rounded to 1/128 degree
  function automatic longint heading_fine(input longint dx, input longint dy);
    longint x, y, z, xs, ys, h;
    if (dy == 0) return (dx < 0) ? 23040 : 0;
    x = dx * 256;
    y = dy * 256;
    z = 0;
    if (x < 0) begin
      // left half-plane: turn by 180 degrees first
      x = -x;
      y = -y;
      z = (dy > 0) ? 64'sd1509949440 : -64'sd1509949440;
    end
    for (int i = 0; i < Stages && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + AtanFine[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - AtanFine[i];
      end
    end
    h = (z + 32768) >>> 16;
    if (h > 23040) h = 23040;
    if (h < -23040) h = -23040;
    return h;
  endfunction

  function automatic longint step_len(input longint unsigned p, input longint d,
                                      input longint unsigned len);
    longint unsigned mag;
    longint m;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    m   = longint'((p * mag) / (64'd256 * len));
    return (d < 0) ? -m : m;
  endfunction

  function automatic longint clamp_pos(input longint v);
    if (v > PosMax) return PosMax;
    if (v < PosMin) return PosMin;
    return v;
  endfunction

  function automatic move_t predict_move(input point_t pt, input logic [7:0] rad);
    move_t r;
    longint cx, cy, dx, dy;
    longint unsigned s, len, p;
    cx  = longint'(pt.cx);
    cy  = longint'(pt.cy);
    dx  = longint'(pt.tx) - cx;
    dy  = longint'(pt.ty) - cy;
    s   = longint'(dx * dx) + longint'(dy * dy);
    len = root_floor(s);
    if ((len >> 8) <= rad) begin
      r.nx  = pt.cx;
      r.ny  = pt.cy;
      r.hd  = '0;
      r.arr = 1'b1;
    end else begin
      p     = longint'(pt.spd) * longint'(pt.ft);
      r.nx  = 24'(clamp_pos(cx + step_len(p, dx, len)));
      r.ny  = 24'(clamp_pos(cy + step_len(p, dy, len)));
      r.hd  = 16'(heading_fine(dx, dy));
      r.arr = 1'b0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- sender
  task automatic send_point(input point_t pt);
    while (!calm && $urandom_range(99) < 25) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.current_x  <= pt.cx;
    in_if.current_y  <= pt.cy;
    in_if.target_x   <= pt.tx;
    in_if.target_y   <= pt.ty;
    in_if.speed      <= pt.spd;
    in_if.frame_time <= pt.ft;
    // ready seen at the falling edge holds through the next rising edge
    do @(negedge clk_i); while (!in_if.ready);
    pending_moves.push_back(predict_move(pt, radius_q));
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_moves.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  task automatic write_radius(input logic [7:0] v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    radius_q     = v;
  endtask

  function automatic logic signed [23:0] wrap_pos(input longint v);
    return 24'(clamp_pos(v));
  endfunction

  // random point: half close pairs, the rest axis-aligned or full-range
  function automatic point_t rand_point();
    point_t pt;
    int unsigned kind;
    longint reach;
    kind   = $urandom_range(9);
    pt.cx  = 24'($urandom());
    pt.cy  = 24'($urandom());
    pt.spd = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(400));
    pt.ft  = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(2000));
    reach  = (longint'(radius_q) + 4) * 512;
    case (kind)
      0, 1, 2: begin
        pt.tx = 24'($urandom());
        pt.ty = 24'($urandom());
      end
      3: begin
        pt.tx = 24'($urandom());
        pt.ty = pt.cy;
      end
      4: begin
        pt.tx = pt.cx;
        pt.ty = 24'($urandom());
      end
      default: begin
        pt.tx = wrap_pos(longint'(pt.cx) + longint'($urandom_range(2 * reach)) - reach);
        pt.ty = wrap_pos(longint'(pt.cy) + longint'($urandom_range(2 * reach)) - reach);
      end
    endcase
    return pt;
  endfunction

  function automatic point_t mk(input longint cx, cy, tx, ty, input int spd, ft);
    point_t pt;
    pt.cx  = 24'(cx);
    pt.cy  = 24'(cy);
    pt.tx  = 24'(tx);
    pt.ty  = 24'(ty);
    pt.spd = 16'(spd);
    pt.ft  = 16'(ft);
    return pt;
  endfunction

  // ---------------------------------------------------------------- receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_req != 0) begin
      out_if.ready <= 1'b0;
      hold_req     <= hold_req - 1;
    end else begin
      out_if.ready <= calm || ($urandom_range(99) >= 25);
    end
  end

  // compare each accepted word with the oldest prediction
  always @(negedge clk_i) begin
    move_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_moves.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word at %0t", $realtime);
      end else begin
        want = pending_moves.pop_front();
        if (out_if.new_x !== want.nx || out_if.new_y !== want.ny ||
            out_if.heading !== want.hd || out_if.arrived !== want.arr) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word mismatch at %0t: x %0d/%0d y %0d/%0d hd %0d/%0d arr %0b/%0b",
                     $realtime, want.nx, out_if.new_x, want.ny, out_if.new_y,
                     want.hd, out_if.heading, want.arr, out_if.arrived);
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    send_point(mk(0, 0, 0, 0, 100, 1000));                       // zero vector
    send_point(mk(0, 0, 3 * 256 + 255, 0, 100, 1000));           // at radius edge
    send_point(mk(0, 0, 4 * 256, 0, 100, 1000));                 // just outside
    send_point(mk(0, 0, 10000, 0, 300, 5000));                   // +x axis
    send_point(mk(0, 0, -10000, 0, 300, 5000));                  // -x axis
    send_point(mk(0, 0, 0, 10000, 300, 5000));                   // +y axis
    send_point(mk(0, 0, 0, -10000, 300, 5000));                  // -y axis
    send_point(mk(500, 500, -9000, 7000, 50, 3000));             // left, dy>0
    send_point(mk(500, 500, -9000, -7000, 50, 3000));            // left, dy<0
    send_point(mk(0, 0, 5000, 5000, 0, 65535));                  // zero speed
    send_point(mk(0, 0, 5000, -5000, 65535, 0));                 // zero time
    send_point(mk(PosMax, PosMax, PosMin, PosMin, 65535, 65535));
    send_point(mk(PosMin, PosMin, PosMax, PosMax, 65535, 65535));
    send_point(mk(PosMax - 100, 0, PosMax, 0, 65535, 65535));    // overshoot, saturate
    send_point(mk(PosMin + 100, 0, PosMin, 0, 65535, 65535));
    send_point(mk(0, PosMax - 9000, 0, PosMax, 65535, 65535));
    send_point(mk(0, PosMin + 9000, 0, PosMin, 65535, 65535));
    send_point(mk(PosMin, PosMax, PosMax, PosMin, 1, 1));
    send_point(mk(-1, -1, 2000, -2000, 65535, 65535));
    send_point(mk(0, 0, -5000, 1, 100, 100));
  endtask

  task automatic test_radius_sweep();
    logic [7:0] vals [4] = '{8'd0, 8'd255, 8'd1, 8'd128};
    foreach (vals[k]) begin
      write_radius(vals[k]);
      send_point(mk(0, 0, 255, 0, 10, 10));
      send_point(mk(0, 0, 256, 0, 10, 10));
      send_point(mk(0, 0, 255 * 256 + 255, 0, 10, 10));
      send_point(mk(0, 0, 256 * 256, 0, 10, 10));
      repeat (30) send_point(rand_point());
    end
  endtask

  task automatic test_random(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      calm = (i >= n / 3 && i < n / 3 + 200);   // one stretch with no idling
      send_point(rand_point());
    end
    calm = 1'b0;
  endtask

  task automatic test_backpressure();
    calm     = 1'b1;
    hold_req = 400;   // output held off; input must stall once the chain fills
    repeat (150) send_point(rand_point());
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    in_if.valid      = 1'b0;
    in_if.current_x  = '0;
    in_if.current_y  = '0;
    in_if.target_x   = '0;
    in_if.target_y   = '0;
    in_if.speed      = '0;
    in_if.frame_time = '0;
    radius_q         = 8'd3;
    mismatches       = 0;
    calm             = 1'b0;
    hold_req         = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_radius_sweep();
    write_radius(8'd3);
    test_random(700);
    write_radius(8'($urandom()));
    test_random(600);
    test_backpressure();
    write_radius(8'd0);
    test_random(100);

    wait_drained();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run limit
  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
